/* design/swm_pkg.sv */
package swm_pkg;

  localparam int MAX_WINDOW   = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int CFG_BITS     = 4;
  localparam int WINDOW_RESET = 8;

  // Control bits that each cell shows to both of its neighbors.
  typedef struct packed {
    logic valid;    // cell holds a sample
    logic gt;       // cell is empty or its sample is greater than the new one
    logic shifted;  // the evicted sample sits at this cell or below it
  } swm_link_t;

endpackage

/* design/swm_cell.sv */
module swm_cell #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS,
  parameter int AGE_BITS    = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          step,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic        [AGE_BITS-1:0]    win_last,
  input  logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] lo_val,
  input  logic        [AGE_BITS-1:0]    lo_age,
  input  swm_pkg::swm_link_t            lo_link,
  input  logic signed [SAMPLE_BITS-1:0] hi_val,
  input  logic        [AGE_BITS-1:0]    hi_age,
  input  swm_pkg::swm_link_t            hi_link,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic        [AGE_BITS-1:0]    age,
  output swm_pkg::swm_link_t            link
);

  logic                          valid;
  logic                          evict;
  logic                          gt_self;
  logic                          shifted;
  logic signed [SAMPLE_BITS-1:0] a_val;
  logic        [AGE_BITS-1:0]    a_age;
  logic                          a_valid;
  logic                          a_gt;
  logic signed [SAMPLE_BITS-1:0] b_val;
  logic        [AGE_BITS-1:0]    b_age;
  logic                          b_valid;
  logic                          b_gt;
  logic signed [SAMPLE_BITS-1:0] val_next;
  logic        [AGE_BITS-1:0]    age_next;
  logic                          valid_next;

  // The oldest sample leaves once the window is full.
  assign evict   = full && valid && (age == win_last);
  assign gt_self = !valid || (val > x);
  assign shifted = lo_link.shifted | evict;

  assign link = '{valid: valid, gt: gt_self, shifted: shifted};

  // Contents of this position and the one below after the eviction closes the gap.
  assign a_val   = shifted ? hi_val : val;
  assign a_age   = shifted ? hi_age : age;
  assign a_valid = shifted ? hi_link.valid : valid;
  assign a_gt    = shifted ? hi_link.gt : gt_self;

  assign b_val   = lo_link.shifted ? val : lo_val;
  assign b_age   = lo_link.shifted ? age : lo_age;
  assign b_valid = lo_link.shifted ? valid : lo_link.valid;
  assign b_gt    = lo_link.shifted ? gt_self : lo_link.gt;

  // The new sample goes to the lowest position whose compacted content is greater.
  always_comb begin
    if (a_gt && b_gt) begin
      val_next   = b_val;
      age_next   = b_age + 1'b1;
      valid_next = b_valid;
    end else if (a_gt) begin
      val_next   = x;
      age_next   = '0;
      valid_next = 1'b1;
    end else begin
      val_next   = a_val;
      age_next   = a_age + 1'b1;
      valid_next = a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (step) begin
      valid <= valid_next;
    end
    if (step) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

/* design/sliding_window_median.sv */
// Sliding-window median over a sorted chain of cells with age tags.
// The chain takes the sample at the accepting edge; the output register loads the
// median once it is free, that is, when the result is not held by result_stall.
// Throughput: one sample per cycle while result_stall is low; the chain inserts one
// sample and evicts the oldest at once; the output register frees it for the next.
// Reset (synchronous, active high) empties the window and sets the window size to 8, clipped to MAX_WINDOW.
module sliding_window_median #(
  parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [swm_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [SAMPLE_BITS:0]         median_doubled,
  output logic [$clog2(MAX_WINDOW+1)-1:0]     samples_held
);

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_RESET =
      (swm_pkg::WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : swm_pkg::WINDOW_RESET;

  logic [CW-1:0]                 eff_win;
  logic [CW-1:0]                 cfg_eff;
  logic [CW-1:0]                 count;
  logic [AW-1:0]                 win_last;
  logic                          full;
  logic                          step;
  logic                          pending;
  logic                          out_load;
  logic [AW-1:0]                 lo_idx;
  logic [AW-1:0]                 hi_idx;
  logic signed [SAMPLE_BITS-1:0] mid_a;
  logic signed [SAMPLE_BITS-1:0] mid_b;

  logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
  logic        [AW-1:0]          cell_age [MAX_WINDOW];
  swm_pkg::swm_link_t            cell_link [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] lo_val [MAX_WINDOW];
  logic        [AW-1:0]          lo_age [MAX_WINDOW];
  swm_pkg::swm_link_t            lo_link [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] hi_val [MAX_WINDOW];
  logic        [AW-1:0]          hi_age [MAX_WINDOW];
  swm_pkg::swm_link_t            hi_link [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]         cell_valid;

  // A size of zero acts as one; a size above the chain length is clipped.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_eff = CW'(1);
    end else if (int'(cfg_data) > MAX_WINDOW) begin
      cfg_eff = CW'(MAX_WINDOW);
    end else begin
      cfg_eff = CW'(cfg_data);
    end
  end

  assign win_last     = AW'(eff_win - 1'b1);
  assign full         = (count == eff_win);
  assign out_load     = pending && (!result_valid || !result_stall);
  assign sample_stall = pending && !out_load;
  assign step         = sample_valid && !sample_stall;

  genvar g;
  generate
    for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
      if (g == 0) begin : g_lo_edge
        assign lo_val[g]  = '0;
        assign lo_age[g]  = '0;
        assign lo_link[g] = '{valid: 1'b0, gt: 1'b0, shifted: 1'b0};
      end else begin : g_lo
        assign lo_val[g]  = cell_val[g-1];
        assign lo_age[g]  = cell_age[g-1];
        assign lo_link[g] = cell_link[g-1];
      end
      // Past the top of the chain everything counts as empty.
      if (g == MAX_WINDOW - 1) begin : g_hi_edge
        assign hi_val[g]  = '0;
        assign hi_age[g]  = '0;
        assign hi_link[g] = '{valid: 1'b0, gt: 1'b1, shifted: 1'b0};
      end else begin : g_hi
        assign hi_val[g]  = cell_val[g+1];
        assign hi_age[g]  = cell_age[g+1];
        assign hi_link[g] = cell_link[g+1];
      end

      swm_cell #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .AGE_BITS   (AW)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .clear   (cfg_write),
        .step    (step),
        .x       (sample),
        .win_last(win_last),
        .full    (full),
        .lo_val  (lo_val[g]),
        .lo_age  (lo_age[g]),
        .lo_link (lo_link[g]),
        .hi_val  (hi_val[g]),
        .hi_age  (hi_age[g]),
        .hi_link (hi_link[g]),
        .val     (cell_val[g]),
        .age     (cell_age[g]),
        .link    (cell_link[g])
      );

      assign cell_valid[g] = cell_link[g].valid;
    end
  endgenerate

  // For an odd count both middle positions are the same cell.
  assign lo_idx = AW'((count - 1'b1) >> 1);
  assign hi_idx = AW'(count >> 1);

  always_comb begin
    mid_a = '0;
    mid_b = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (AW'(i) == lo_idx) begin
        mid_a = cell_val[i];
      end
      if (AW'(i) == hi_idx) begin
        mid_b = cell_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_win      <= CW'(WIN_RESET);
      count        <= '0;
      pending      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        eff_win <= cfg_eff;
        count   <= '0;
      end else if (step && !full) begin
        count <= count + 1'b1;
      end
      if (step) begin
        pending <= 1'b1;
      end else if (out_load) begin
        pending <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (out_load) begin
      median_doubled <= {mid_a[SAMPLE_BITS-1], mid_a} + {mid_b[SAMPLE_BITS-1], mid_b};
      samples_held   <= count;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= eff_win)
    else $error("fill count exceeds window size");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("occupied cells disagree with fill count");

  a_step_pending: assert property (@(posedge clk) disable iff (rst)
    step |=> pending)
    else $error("accepted sample left no pending result");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> result_valid)
    else $error("loaded result not shown");
`endif

endmodule
